// ===== rtl/u2frsm_pkg.sv =====
// ----------------------------------------------------------------------------
// u2frsm_pkg
// Shared types and constants of the U2F HID packet reassembler.
// ----------------------------------------------------------------------------
package u2frsm_pkg;

  localparam int MSG_BYTES = 1024;
  localparam int PKT_BYTES = 64;
  localparam int ADDR_W    = $clog2(MSG_BYTES);
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = QPTR_W + 1;

  localparam logic [10:0] OFS_LIMIT  = 11'(MSG_BYTES - 3);
  localparam logic [7:0]  CMD_PING   = 8'h81;
  localparam logic [7:0]  CMD_MSG    = 8'h83;
  localparam logic [7:0]  CMD_INIT   = 8'h86;
  localparam logic [31:0] CHAN_BCAST = 32'hffff_ffff;

  typedef enum logic [1:0] {
    FUNC_PKT = 2'd0,
    FUNC_REL = 2'd1,
    FUNC_RD  = 2'd2,
    FUNC_NOP = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_SEG  = 2'd1,
    MODE_PROC = 2'd2,
    MODE_SEND = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_PARTIAL = 2'd0,
    ST_CMPL    = 2'd1,
    ST_ERR     = 2'd2,
    ST_RDATA   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ERR_BUSY     = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_LONG     = 3'd2,
    ERR_CMD      = 3'd3,
    ERR_UNEXP    = 3'd4,
    ERR_SEQ      = 3'd5,
    ERR_OVERFLOW = 3'd6
  } err_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  error_code;
    logic        transport_reset;
    logic [7:0]  command_byte;
    logic [15:0] command_length;
    logic [7:0]  read_data;
  } res_t;

endpackage

// ===== rtl/u2frsm_if.sv =====
// ----------------------------------------------------------------------------
// u2frsm_in_if / u2frsm_out_if
// Word channels of the reassembler: report words in, outcome words out.
// ----------------------------------------------------------------------------
interface u2frsm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;
  logic       last_of_packet;
  logic [9:0] read_index;

  modport source (output valid, func, data_byte, last_of_packet, read_index,
                  input ready);
  modport sink (input valid, func, data_byte, last_of_packet, read_index,
                output ready);
endinterface

interface u2frsm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  error_code;
  logic        transport_reset;
  logic [7:0]  command_byte;
  logic [15:0] command_length;
  logic [7:0]  read_data;

  modport source (output valid, status, error_code, transport_reset, command_byte,
                  command_length, read_data, input ready);
  modport sink (input valid, status, error_code, transport_reset, command_byte,
                command_length, read_data, output ready);
endinterface

// ===== rtl/u2frsm_front.sv =====
// ----------------------------------------------------------------------------
// u2frsm_front
// Takes words, tracks the transport, fills the message store and classifies
// each packet end; hands one registered outcome per result-bearing word on.
// ----------------------------------------------------------------------------
module u2frsm_front
  import u2frsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [1:0]  func,
  input  logic [7:0]  data_byte,
  input  logic        last_of_packet,
  input  logic [9:0]  read_index,
  input  logic [31:0] chan_id,
  output logic        push,
  output res_t        push_res
);

  mode_t            mode_r, mode_nxt;
  logic [10:0]      comm_r, comm_nxt;
  logic [10:0]      tent_r, tent_nxt;
  logic [7:0]       seq_r, seq_nxt;
  logic [15:0]      pend_r, pend_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic [6:0][7:0]  hdr_r, hdr_nxt;
  logic [7:0]       byte0_r, byte0_nxt;
  logic             s1_v_r, s1_rd_r;
  res_t             s1_res_r;
  logic [7:0]       rdata_r;
  logic [7:0]       mem [MSG_BYTES];

  logic             res_v;
  res_t             res;
  logic             we;
  logic [10:0]      wa;
  logic [6:0]       size;
  logic             fail, ok;
  logic [2:0]       fcode;
  logic [10:0]      comm_new;
  logic [15:0]      pend_new;
  logic [31:0]      ch;
  logic [11:0]      grow;
  logic             open;

  always_comb begin
    mode_nxt  = mode_r;
    comm_nxt  = comm_r;
    tent_nxt  = tent_r;
    seq_nxt   = seq_r;
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    hdr_nxt   = hdr_r;
    byte0_nxt = byte0_r;
    res_v     = 1'b0;
    res       = '0;
    we        = 1'b0;
    wa        = '0;
    size      = '0;
    fail      = 1'b0;
    ok        = 1'b0;
    fcode     = ERR_BUSY;
    comm_new  = comm_r;
    pend_new  = pend_r;
    ch        = '0;
    grow      = '0;
    open      = (mode_r == MODE_IDLE) || (mode_r == MODE_SEG);
    if (acc) begin
      unique case (func_t'(func))
        FUNC_PKT: begin
          if (cnt_r < 7'(PKT_BYTES)) begin
            if (cnt_r < 7'd7) hdr_nxt[cnt_r[2:0]] = data_byte;
            if (cnt_r == 7'd4) tent_nxt = data_byte[7] ? 11'd0 : comm_r;
            if (open && cnt_r >= 7'd4 &&
                (hdr_nxt[4][7] || (mode_r == MODE_SEG && cnt_r >= 7'd5))) begin
              we       = ({1'b0, tent_nxt} < 12'(MSG_BYTES));
              wa       = tent_nxt;
              tent_nxt = tent_nxt + 11'd1;
            end
            cnt_nxt = cnt_r + 7'd1;
          end
          if (we && wa == 11'd0) byte0_nxt = data_byte;
          if (last_of_packet) begin
            size    = cnt_nxt;
            cnt_nxt = '0;
            res_v   = 1'b1;
            ch      = {hdr_nxt[0], hdr_nxt[1], hdr_nxt[2], hdr_nxt[3]};
            grow    = {1'b0, comm_r} + 12'(size) - 12'd5;
            priority if (mode_r == MODE_PROC || mode_r == MODE_SEND) begin
              res.status = ST_ERR;
            end else if (size < 7'd5) begin
              fail = 1'b1; fcode = ERR_SHORT;
            end else if (hdr_nxt[4][7]) begin
              priority if (size < 7'd8) begin
                fail = 1'b1; fcode = ERR_SHORT;
              end else if (ch != chan_id && !(ch == CHAN_BCAST && hdr_nxt[4] == CMD_INIT)) begin
                fail = 1'b1; fcode = ERR_BUSY;
              end else if ({hdr_nxt[5], hdr_nxt[6]} > {5'd0, OFS_LIMIT}) begin
                fail = 1'b1; fcode = ERR_LONG;
              end else if (hdr_nxt[4] != CMD_PING && hdr_nxt[4] != CMD_MSG &&
                           hdr_nxt[4] != CMD_INIT) begin
                fail = 1'b1; fcode = ERR_CMD;
              end else begin
                ok       = 1'b1;
                pend_new = {hdr_nxt[5], hdr_nxt[6]};
                seq_nxt  = '0;
                comm_new = 11'(size) - 11'd4;
              end
            end else begin
              priority if (size < 7'd6) begin
                fail = 1'b1; fcode = ERR_SHORT;
              end else if (mode_r != MODE_SEG) begin
                fail = 1'b1; fcode = ERR_UNEXP;
              end else if (hdr_nxt[4] != seq_r) begin
                fail = 1'b1; fcode = ERR_SEQ;
              end else if (grow > {1'b0, OFS_LIMIT}) begin
                fail = 1'b1; fcode = ERR_OVERFLOW;
              end else begin
                ok       = 1'b1;
                comm_new = grow[10:0];
                seq_nxt  = seq_r + 8'd1;
              end
            end
            if (fail) begin
              mode_nxt = MODE_IDLE;
              comm_nxt = '0;
              tent_nxt = '0;
              seq_nxt  = '0;
              pend_nxt = '0;
              res.status          = ST_ERR;
              res.error_code      = fcode;
              res.transport_reset = 1'b1;
            end
            if (ok) begin
              comm_nxt = comm_new;
              pend_nxt = pend_new;
              tent_nxt = comm_new;
              if ({6'd0, comm_new} >= {1'b0, pend_new} + 17'd3) begin
                mode_nxt           = MODE_PROC;
                res.status         = ST_CMPL;
                res.command_byte   = byte0_nxt;
                res.command_length = pend_new;
              end else begin
                mode_nxt = MODE_SEG;
              end
            end
            hdr_nxt = '0;
          end
        end
        FUNC_REL: begin
          mode_nxt = MODE_IDLE;
          comm_nxt = '0;
          tent_nxt = '0;
          seq_nxt  = '0;
          pend_nxt = '0;
          cnt_nxt  = '0;
          hdr_nxt  = '0;
        end
        FUNC_RD: begin
          res_v      = 1'b1;
          res.status = ST_RDATA;
        end
        FUNC_NOP: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      comm_r <= '0;
      tent_r <= '0;
      seq_r  <= '0;
      pend_r <= '0;
      cnt_r  <= '0;
      hdr_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      comm_r <= comm_nxt;
      tent_r <= tent_nxt;
      seq_r  <= seq_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      hdr_r  <= hdr_nxt;
      s1_v_r <= res_v;
    end
  end

  always_ff @(posedge clk) begin
    byte0_r  <= byte0_nxt;
    s1_res_r <= res;
    s1_rd_r  <= acc && (func == FUNC_RD);
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa[ADDR_W-1:0]] <= data_byte;
    if (acc && func == FUNC_RD) rdata_r <= mem[read_index[ADDR_W-1:0]];
  end

  always_comb begin
    push_res = s1_res_r;
    push_res.read_data = s1_rd_r ? rdata_r : 8'd0;
  end

  assign push = s1_v_r;

endmodule

// ===== rtl/u2frsm_queue.sv =====
// ----------------------------------------------------------------------------
// u2frsm_queue
// Short outcome queue feeding the result channel.
// ----------------------------------------------------------------------------
module u2frsm_queue
  import u2frsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  res_t              push_res,
  output logic [QCNT_W-1:0] count,
  u2frsm_out_if.source      out_chan
);

  res_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              pop;
  res_t              head;

  assign pop  = out_chan.valid && out_chan.ready;
  assign head = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QPTR_W'(1);
      if (pop) rp_r <= rp_r + QPTR_W'(1);
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_res;
  end

  assign count                    = cnt_r;
  assign out_chan.valid           = (cnt_r != '0);
  assign out_chan.status          = head.status;
  assign out_chan.error_code      = head.error_code;
  assign out_chan.transport_reset = head.transport_reset;
  assign out_chan.command_byte    = head.command_byte;
  assign out_chan.command_length  = head.command_length;
  assign out_chan.read_data       = head.read_data;

endmodule

// ===== rtl/u2fhid_packet_reassembler.sv =====
// ----------------------------------------------------------------------------
// u2fhid_packet_reassembler
// U2F HID report reassembler with message store and readback.
//
// in_chan carries one word per handshake: a report byte with its
// end-of-report mark, a transport release, a store read or a no-op.
// out_chan returns one outcome word for each report end and each read;
// release, no-op and plain report bytes give none. cfg_* is an APB
// write/read port for the channel identifier at address 0.
// One word is taken per cycle while in_chan.ready is high. An outcome
// passes through the classifier and store-read register and then the
// four-word outcome queue before it appears on out_chan. in_chan.ready
// drops only when the queue and the word in flight fill it, i.e. when
// out_chan has been stalled; nothing is lost or repeated across stalls.
// Synchronous reset puts the transport to idle, empties the queue and
// clears the channel identifier. The message store is not cleared; its
// entries are defined once written.
// ----------------------------------------------------------------------------
module u2fhid_packet_reassembler
  import u2frsm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  u2frsm_in_if.sink    in_chan,
  u2frsm_out_if.source out_chan,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [31:0]       chan_r;
  logic              acc;
  logic              push;
  res_t              push_res;
  logic [QCNT_W-1:0] count;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : chan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      chan_r <= cfg_pwdata;
    end
  end

  assign in_chan.ready = ({1'b0, count} + (QCNT_W+1)'(push)) < (QCNT_W+1)'(QDEPTH);
  assign acc = in_chan.valid && in_chan.ready;

  u2frsm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (acc),
    .func           (in_chan.func),
    .data_byte      (in_chan.data_byte),
    .last_of_packet (in_chan.last_of_packet),
    .read_index     (in_chan.read_index),
    .chan_id        (chan_r),
    .push           (push),
    .push_res       (push_res)
  );

  u2frsm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (push_res),
    .count    (count),
    .out_chan (out_chan)
  );

endmodule

// ===== verif/u2fhid_packet_reassembler_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// u2fhid_packet_reassembler_checker
// Watches both word channels of the reassembler, predicts the outcome of
// every accepted input word and compares each outcome word field by field.
// ----------------------------------------------------------------------------
module u2fhid_packet_reassembler_checker
  import u2frsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  u2frsm_in_if        in_chan,
  u2frsm_out_if       out_chan,
  input  logic [31:0] chan_id,
  output int          fail_count,
  output int          pending_count
);

  mode_t       mode;
  logic [10:0] commit_ofs;
  logic [10:0] tent_ofs;
  logic [7:0]  next_seq;
  logic [15:0] decl_len;
  logic [6:0]  byte_cnt;
  logic [7:0]  hdr [0:6];
  logic [7:0]  store [0:MSG_BYTES-1];
  res_t        outcome_q [$];
  int          mismatches;

  assign pending_count = outcome_q.size();
  assign fail_count    = mismatches;

  function automatic res_t mk(status_t st, err_t e, logic rst, logic [7:0] cb,
                              logic [15:0] ln, logic [7:0] rd);
    res_t r;
    r.status = st; r.error_code = e; r.transport_reset = rst;
    r.command_byte = cb; r.command_length = ln; r.read_data = rd;
    return r;
  endfunction

  task automatic go_idle();
    mode = MODE_IDLE; commit_ofs = '0; tent_ofs = '0; next_seq = '0; decl_len = '0;
  endtask

  task automatic abort_packet(err_t e);
    go_idle();
    outcome_q.push_back(mk(ST_ERR, e, 1'b1, '0, '0, '0));
  endtask

  task automatic finish_packet(int unsigned size);
    logic [31:0] ch;
    int unsigned ln;
    if (mode == MODE_PROC || mode == MODE_SEND) begin
      outcome_q.push_back(mk(ST_ERR, ERR_BUSY, 1'b0, '0, '0, '0));
      return;
    end
    if (size < 5) begin
      abort_packet(ERR_SHORT);
      return;
    end
    if (hdr[4][7]) begin
      ch = {hdr[0], hdr[1], hdr[2], hdr[3]};
      ln = {hdr[5], hdr[6]};
      if (size < 8) begin
        abort_packet(ERR_SHORT);
        return;
      end
      if (ch != chan_id && !(ch == CHAN_BCAST && hdr[4] == CMD_INIT)) begin
        abort_packet(ERR_BUSY);
        return;
      end
      if (ln > MSG_BYTES - 3) begin
        abort_packet(ERR_LONG);
        return;
      end
      if (hdr[4] != CMD_PING && hdr[4] != CMD_MSG && hdr[4] != CMD_INIT) begin
        abort_packet(ERR_CMD);
        return;
      end
      decl_len = ln; next_seq = '0; commit_ofs = 11'(size - 4);
    end else begin
      if (size < 6) begin
        abort_packet(ERR_SHORT);
        return;
      end
      if (mode != MODE_SEG) begin
        abort_packet(ERR_UNEXP);
        return;
      end
      if (hdr[4] != next_seq) begin
        abort_packet(ERR_SEQ);
        return;
      end
      if (int'(commit_ofs) + size - 5 > MSG_BYTES - 3) begin
        abort_packet(ERR_OVERFLOW);
        return;
      end
      commit_ofs = commit_ofs + 11'(size - 5);
      next_seq = next_seq + 8'd1;
    end
    tent_ofs = commit_ofs;
    if (int'(commit_ofs) >= int'(decl_len) + 3) begin
      mode = MODE_PROC;
      outcome_q.push_back(mk(ST_CMPL, ERR_BUSY, 1'b0, store[0], decl_len, '0));
    end else begin
      mode = MODE_SEG;
      outcome_q.push_back(mk(ST_PARTIAL, ERR_BUSY, 1'b0, '0, '0, '0));
    end
  endtask

  task automatic take_word(func_t f, logic [7:0] b, logic last, logic [9:0] idx);
    int unsigned i;
    int unsigned size;
    case (f)
      FUNC_REL: begin
        go_idle();
        byte_cnt = '0;
        for (int k = 0; k < 7; k++) hdr[k] = '0;
      end
      FUNC_RD: outcome_q.push_back(mk(ST_RDATA, ERR_BUSY, 1'b0, '0, '0, store[idx]));
      FUNC_PKT: begin
        if (byte_cnt < PKT_BYTES) begin
          i = byte_cnt;
          if (i < 7) hdr[i] = b;
          if (i == 4) tent_ofs = b[7] ? 11'd0 : commit_ofs;
          if ((mode == MODE_IDLE || mode == MODE_SEG) && i >= 4 &&
              (hdr[4][7] || (mode == MODE_SEG && i >= 5))) begin
            if (tent_ofs < MSG_BYTES) store[tent_ofs[9:0]] = b;
            tent_ofs = tent_ofs + 11'd1;
          end
          byte_cnt = 7'(i + 1);
        end
        if (last) begin
          size = byte_cnt;
          byte_cnt = '0;
          finish_packet(size);
          for (int k = 0; k < 7; k++) hdr[k] = '0;
        end
      end
      default: ;
    endcase
  endtask

  initial begin
    mismatches = 0;
    go_idle();
    byte_cnt = '0;
    for (int k = 0; k < 7; k++) hdr[k] = '0;
    for (int k = 0; k < MSG_BYTES; k++) store[k] = '0;
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected outcome word st=%0d", out_chan.status);
        end else begin
          want = outcome_q.pop_front();
          if (out_chan.status !== want.status || out_chan.error_code !== want.error_code ||
              out_chan.transport_reset !== want.transport_reset ||
              out_chan.command_byte !== want.command_byte ||
              out_chan.command_length !== want.command_length ||
              out_chan.read_data !== want.read_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d err=%0d rst=%0d cmd=%h len=%0d rd=%h | got st=%0d err=%0d rst=%0d cmd=%h len=%0d rd=%h",
                       want.status, want.error_code, want.transport_reset, want.command_byte,
                       want.command_length, want.read_data, out_chan.status,
                       out_chan.error_code, out_chan.transport_reset, out_chan.command_byte,
                       out_chan.command_length, out_chan.read_data);
          end
        end
      end
      if (in_chan.valid && in_chan.ready)
        take_word(func_t'(in_chan.func), in_chan.data_byte, in_chan.last_of_packet,
                  in_chan.read_index);
    end
  end

endmodule

// ===== verif/u2fhid_packet_reassembler_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// u2fhid_packet_reassembler_test
// Drives reports, releases, no-op words and store reads into the reassembler under
// several channel identifiers and idling and output-stall phases; the checker judges every outcome.
// ----------------------------------------------------------------------------
module u2fhid_packet_reassembler_test;
  import u2frsm_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic [31:0] chan_id = '0;
  int          fail_count, pending_count;
  int          idle_pct, stall_pct;
  logic [1023:0] written = '0;
  logic [7:0]  no_hdr [];

  u2frsm_in_if  in_chan ();
  u2frsm_out_if out_chan ();

  always #2 clk = ~clk;

  u2fhid_packet_reassembler u_dut (
    .clk, .rst_n, .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  u2fhid_packet_reassembler_checker u_chk (
    .clk, .rst_n, .in_chan, .out_chan, .chan_id, .fail_count, .pending_count
  );

  initial begin
    in_chan.valid = 1'b0; in_chan.func = FUNC_PKT; in_chan.data_byte = '0;
    in_chan.last_of_packet = 1'b0; in_chan.read_index = '0;
    out_chan.ready = 1'b0;
  end

  always @(negedge clk)
    out_chan.ready <= ($urandom_range(99) >= stall_pct);

  task automatic send_word(func_t f, logic [7:0] b, logic last, logic [9:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1; in_chan.func <= f; in_chan.data_byte <= b;
    in_chan.last_of_packet <= last; in_chan.read_index <= idx;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_report(logic [7:0] hd [], int size);
    for (int k = 0; k < size; k++)
      send_word(FUNC_PKT, k < hd.size() ? hd[k] : 8'($urandom), k == size - 1, '0);
  endtask

  task automatic init_report(logic [31:0] ch, logic [7:0] cmd, logic [15:0] ln, int size);
    logic [7:0] hd [];
    hd = new[7];
    hd = '{ch[31:24], ch[23:16], ch[15:8], ch[7:0], cmd, ln[15:8], ln[7:0]};
    send_report(hd, size);
    for (int k = 0; k < size - 4 && k < PKT_BYTES - 4; k++) written[k] = 1'b1;
  endtask

  task automatic cont_report(logic [31:0] ch, logic [7:0] seq, int size);
    logic [7:0] hd [];
    hd = new[5];
    hd = '{ch[31:24], ch[23:16], ch[15:8], ch[7:0], seq};
    send_report(hd, size);
  endtask

  task automatic read_word();
    int idx;
    idx = $urandom_range(1023);
    while (!written[idx]) idx = $urandom_range(63);
    send_word(FUNC_RD, 8'($urandom), 1'($urandom), 10'(idx));
  endtask

  task automatic set_channel(logic [31:0] v);
    in_chan.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= '0; cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    chan_id = v;
  endtask

  task automatic random_message();
    int ln, got, seq, sz;
    logic [7:0] cmds [3];
    logic [7:0] cmd;
    cmds = '{CMD_PING, CMD_MSG, CMD_INIT};
    cmd = cmds[$urandom_range(2)];
    ln = $urandom_range(7) == 0 ? $urandom_range(300) : $urandom_range(60);
    sz = $urandom_range(8, 40);
    init_report(($urandom_range(9) == 0 && cmd == CMD_INIT) ? CHAN_BCAST : chan_id,
                cmd, 16'(ln), sz);
    got = (sz > PKT_BYTES ? PKT_BYTES : sz) - 4;
    seq = 0;
    while (got < ln + 3) begin
      sz = $urandom_range(6, 40);
      cont_report(chan_id, ($urandom_range(19) == 0) ? 8'($urandom) : 8'(seq), sz);
      got += sz - 5; seq++;
      if (got > 1021) break;
    end
    read_word();
    send_word(FUNC_REL, 8'($urandom), 1'($urandom), 10'($urandom));
  endtask

  task automatic noise();
    case ($urandom_range(4))
      0: send_report(no_hdr, $urandom_range(1, 70));
      1: init_report(32'($urandom), 8'($urandom), 16'($urandom), $urandom_range(1, 12));
      2: cont_report(chan_id, 8'($urandom), $urandom_range(1, 20));
      3: send_word(FUNC_NOP, 8'($urandom), 1'($urandom), 10'($urandom));
      default: send_word(FUNC_REL, '0, 1'b0, '0);
    endcase
  endtask

  task automatic random_phase(int idle, int stall, int n);
    idle_pct = idle; stall_pct = stall;
    for (int k = 0; k < n; k++)
      if ($urandom_range(1) == 0) noise(); else random_message();
    idle_pct = 0;
  endtask

  initial begin
    idle_pct = 0; stall_pct = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    set_channel(32'h0000_0000);
    init_report(32'h0, CMD_PING, 16'd0, 8);
    read_word();
    init_report(32'h0, CMD_MSG, 16'd0, 8);
    send_word(FUNC_REL, '0, 1'b0, '0);
    send_report(no_hdr, 4);
    init_report(32'h0, CMD_MSG, 16'd0, 7);
    init_report(32'h1, CMD_MSG, 16'd0, 8);
    init_report(CHAN_BCAST, CMD_INIT, 16'd1, 10);
    send_word(FUNC_REL, '0, 1'b0, '0);
    init_report(32'h0, CMD_MSG, 16'hffff, 8);
    init_report(32'h0, 8'hff, 16'd0, 8);
    cont_report(32'h0, 8'd0, 10);
    init_report(32'h0, CMD_MSG, 16'd1021, 70);
    cont_report(32'h0, 8'd0, 5);
    init_report(32'h0, CMD_MSG, 16'd1021, 64);
    cont_report(32'h0, 8'd3, 10);
    set_channel(32'hffff_ffff);
    random_phase(0, 0, 3);
    set_channel(32'($urandom));
    random_phase(88, 0, 2);
    set_channel(32'h0000_0001);
    random_phase(0, 88, 2);
    set_channel(32'($urandom));
    random_phase(35, 35, 2);
    random_phase(0, 0, 2);
    in_chan.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/u2frsm_pkg.sv
rtl/u2frsm_if.sv
rtl/u2frsm_front.sv
rtl/u2frsm_queue.sv
rtl/u2fhid_packet_reassembler.sv
verif/u2fhid_packet_reassembler_checker.sv
verif/u2fhid_packet_reassembler_test.sv
